FILE: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ATES_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define ATES_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: src/ates_pkg.sv
// ----------------------------------------------------------------------------
// ates_pkg
// Shared types, codes and the SGR update function of the terminal screen engine.
// ----------------------------------------------------------------------------
`default_nettype none
package ates_pkg;

   localparam int unsigned COLUMNS_DEF = 80;
   localparam int unsigned ROWS_DEF    = 24;
   localparam int unsigned CELL_W      = 22;
   localparam logic [4:0]  DEF_COLOR   = 5'd16;
   localparam logic [CELL_W-1:0] BLANK_CELL = {DEF_COLOR, DEF_COLOR, 4'd0, 8'd0};

   typedef enum logic [2:0] {
      MODE_CHAR = 3'd0,
      MODE_CSI  = 3'd1,
      MODE_SGR  = 3'd2,
      MODE_CR   = 3'd3,
      MODE_LF   = 3'd4,
      MODE_BS   = 3'd5,
      MODE_READ = 3'd6,
      MODE_NOP  = 3'd7
   } mode_type;

   localparam logic [7:0] CSI_ICH  = 8'h40;
   localparam logic [7:0] CSI_CUU  = 8'h41;
   localparam logic [7:0] CSI_CUD  = 8'h42;
   localparam logic [7:0] CSI_CUF  = 8'h43;
   localparam logic [7:0] CSI_CUB  = 8'h44;
   localparam logic [7:0] CSI_CNL  = 8'h45;
   localparam logic [7:0] CSI_CPL  = 8'h46;
   localparam logic [7:0] CSI_CHA  = 8'h47;
   localparam logic [7:0] CSI_HPA  = 8'h60;
   localparam logic [7:0] CSI_CUP  = 8'h48;
   localparam logic [7:0] CSI_HVP  = 8'h66;
   localparam logic [7:0] CSI_VPA  = 8'h64;
   localparam logic [7:0] CSI_VPR  = 8'h65;
   localparam logic [7:0] CSI_HPR  = 8'h61;
   localparam logic [7:0] CSI_ED   = 8'h4A;
   localparam logic [7:0] CSI_EL   = 8'h4B;
   localparam logic [7:0] CSI_SGR  = 8'h6D;

   localparam logic [16:0] ERASE_TO_END   = 17'd0;
   localparam logic [16:0] ERASE_TO_START = 17'd1;
   localparam logic [16:0] ERASE_ALL      = 17'd2;

   localparam logic [15:0] SGR_RESET    = 16'd0;
   localparam logic [15:0] SGR_STYLE_LO = 16'd1;
   localparam logic [15:0] SGR_STYLE_HI = 16'd4;
   localparam logic [15:0] SGR_FG_LO    = 16'd30;
   localparam logic [15:0] SGR_FG_HI    = 16'd37;
   localparam logic [15:0] SGR_FG_DEF   = 16'd39;
   localparam logic [15:0] SGR_BG_LO    = 16'd40;
   localparam logic [15:0] SGR_BG_HI    = 16'd47;
   localparam logic [15:0] SGR_BG_DEF   = 16'd49;
   localparam logic [15:0] SGR_FGB_LO   = 16'd90;
   localparam logic [15:0] SGR_FGB_HI   = 16'd97;
   localparam logic [15:0] SGR_BGB_LO   = 16'd100;
   localparam logic [15:0] SGR_BGB_HI   = 16'd107;

   localparam logic [0:0] REG_INSERT_MODE = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FILL,
      ST_WCHAR,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [4:0] bg;
      logic [4:0] fg;
      logic [3:0] style;
   } pen_type;

   localparam pen_type PEN_RESET = '{bg: DEF_COLOR, fg: DEF_COLOR, style: 4'd0};

   // Applies one SGR value to the pen; unknown values leave it unchanged.
   function automatic pen_type apply_sgr(input logic [15:0] v, input pen_type pen);
      pen_type p;
      logic [15:0] d;
      p = pen;
      d = 16'd0;
      if (v == SGR_RESET) begin
         p = PEN_RESET;
      end else if (v >= SGR_STYLE_LO && v <= SGR_STYLE_HI) begin
         d = v - SGR_STYLE_LO;
         p.style = pen.style | (4'd1 << d[1:0]);
      end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
         d = v - SGR_FG_LO;
         p.fg = {2'b00, d[2:0]};
      end else if (v == SGR_FG_DEF) begin
         p.fg = DEF_COLOR;
      end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
         d = v - SGR_BG_LO;
         p.bg = {2'b00, d[2:0]};
      end else if (v == SGR_BG_DEF) begin
         p.bg = DEF_COLOR;
      end else if (v >= SGR_FGB_LO && v <= SGR_FGB_HI) begin
         d = v - SGR_FGB_LO;
         p.fg = {2'b01, d[2:0]};
      end else if (v >= SGR_BGB_LO && v <= SGR_BGB_HI) begin
         d = v - SGR_BGB_LO;
         p.bg = {2'b01, d[2:0]};
      end
      return p;
   endfunction

endpackage
`default_nettype wire

FILE: src/ates_ram.sv
// ----------------------------------------------------------------------------
// ates_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ates_ram #(
   parameter int unsigned WIDTH = 22,
   parameter int unsigned DEPTH = 1920
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: src/ansi_terminal_screen_engine_top.sv
// Sequencing: cursor, CR, LF, BS and SGR items go from IDLE to RESP, where their
// result shows; a character write passes through WCHAR and a cell read through READ.
// Erase and ICH blanking clear one cell per FILL step; a line shift (ICH or insert-mode
// write) reads each cell in SHIFT_RD and writes it in SHIFT_WR on the single port pair.
// Reset: synchronous; afterwards a clearing pass writes COLUMNS*ROWS blank cells
// (1920 by default) while req_tready stays low; CSR writes are taken throughout.
// ----------------------------------------------------------------------------
// ansi_terminal_screen_engine_top
// Text-terminal screen engine: cursor, pen and cell store behind a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module ansi_terminal_screen_engine_top #(
   parameter int unsigned COLUMNS = ates_pkg::COLUMNS_DEF,
   parameter int unsigned ROWS    = ates_pkg::ROWS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata fields from bit 0: mode(3) char_code(8) first_param(16)
   // second_param(16) cell_column(7) cell_row(5), one pad bit.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,
   // rsp_tdata fields from bit 0: cursor_column(7) cursor_row(5) cell_char(8)
   // cell_style(4) cell_fg(5) cell_bg(5), six pad bits.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int unsigned TOTAL = COLUMNS * ROWS;
   localparam int unsigned AW    = $clog2(TOTAL);
   localparam int unsigned XW    = $clog2(COLUMNS + 1);
   localparam int unsigned YW    = $clog2(ROWS);
   localparam int unsigned CW    = $clog2(COLUMNS);
   localparam int unsigned CELLW = ates_pkg::CELL_W;
   localparam logic [16:0] LASTX = 17'(COLUMNS - 1);
   localparam logic [16:0] LASTY = 17'(ROWS - 1);
   localparam logic [16:0] COLS17 = 17'(COLUMNS);
   localparam logic [16:0] LASTA = 17'(TOTAL - 1);

   // Input fields.
   ates_pkg::mode_type in_mode;
   logic [7:0]  in_char;
   logic [15:0] in_p1;
   logic [15:0] in_p2;
   logic [6:0]  in_col;
   logic [4:0]  in_row;

   assign in_mode = ates_pkg::mode_type'(req_tdata[2:0]);
   assign in_char = req_tdata[10:3];
   assign in_p1   = req_tdata[26:11];
   assign in_p2   = req_tdata[42:27];
   assign in_col  = req_tdata[49:43];
   assign in_row  = req_tdata[54:50];

   // State.
   ates_pkg::state_type state_ff, state_in;
   logic [XW-1:0]      x_ff, x_in;
   logic [YW-1:0]      y_ff, y_in;
   ates_pkg::pen_type  pen_ff, pen_in;
   logic               insert_ff, insert_in;
   logic [CELLW-1:0]   cell_ff, cell_in;
   logic [AW-1:0]      fill_addr_ff, fill_addr_in;
   logic [AW-1:0]      fill_hi_ff, fill_hi_in;
   logic               pend_fill_ff, pend_fill_in;
   logic               pend_wchar_ff, pend_wchar_in;
   logic [AW-1:0]      wchar_addr_ff, wchar_addr_in;
   logic [CELLW-1:0]   wchar_data_ff, wchar_data_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [CW-1:0]      sh_col_ff, sh_col_in;
   logic [XW-1:0]      sh_stop_ff, sh_stop_in;
   logic [XW-1:0]      sh_n_ff, sh_n_in;
   logic [AW-1:0]      read_addr_ff, read_addr_in;

   // Decoded item.
   logic [16:0] d_x, d_y;
   ates_pkg::pen_type d_pen;
   logic        d_shift, d_fill, d_wchar, d_read, d_blank;
   logic [16:0] d_n, d_stop, d_lo, d_hi, d_waddr, d_raddr, d_base;
   logic [CELLW-1:0] d_wdata;

   // RAM port.
   logic             ram_we;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [CELLW-1:0] ram_wdata, ram_rdata;

   logic accept, csr_write;

   assign accept    = req_tvalid && req_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ates_pkg::REG_INSERT_MODE) ? {31'd0, insert_ff} : 32'd0;

   function automatic logic [16:0] sat_c(input logic [16:0] v);
      return (v > LASTX) ? LASTX : v;
   endfunction

   function automatic logic [16:0] sat_r(input logic [16:0] v);
      return (v > LASTY) ? LASTY : v;
   endfunction

   function automatic logic [16:0] sub_floor(input logic [16:0] a, input logic [16:0] b);
      return (b > a) ? 17'd0 : a - b;
   endfunction

   function automatic logic [16:0] abs_pos(input logic [15:0] p);
      return (p == 16'd0) ? 17'd0 : 17'(p) - 17'd1;
   endfunction

   // Item decode: next cursor and pen, plus the cell work that the item needs.
   always_comb begin : decode
      logic [16:0] xe, ye, p1e, x0, y0, rem, row_sel, here, incl, lo_r, hi_r;
      logic        wrap, whole;
      xe   = 17'(x_ff);
      ye   = 17'(y_ff);
      p1e  = 17'(in_p1);
      wrap = (xe >= COLS17);
      x0   = wrap ? 17'd0 : xe;
      y0   = wrap ? sat_r(ye + 17'd1) : ye;
      case (in_mode)
         ates_pkg::MODE_READ: row_sel = 17'(in_row);
         ates_pkg::MODE_CHAR: row_sel = y0;
         default:             row_sel = ye;
      endcase
      // The one multiplier: row times line length.
      d_base  = 17'(row_sel * COLS17);
      d_x     = xe;
      d_y     = ye;
      d_pen   = pen_ff;
      d_shift = 1'b0;
      d_fill  = 1'b0;
      d_wchar = 1'b0;
      d_read  = 1'b0;
      d_blank = 1'b0;
      d_n     = 17'd1;
      d_stop  = 17'd0;
      d_lo    = 17'd0;
      d_hi    = 17'd0;
      d_waddr = d_base + x0;
      d_wdata = {pen_ff, in_char};
      d_raddr = d_base + 17'(in_col);
      rem     = COLS17 - xe;
      whole   = (in_char == ates_pkg::CSI_ED);
      here    = d_base + xe;
      incl    = d_base + sat_c(xe);
      lo_r    = whole ? 17'd0 : d_base;
      hi_r    = whole ? LASTA : d_base + LASTX;
      case (in_mode)
         ates_pkg::MODE_CHAR: begin
            d_x     = x0 + 17'd1;
            d_y     = y0;
            d_wchar = 1'b1;
            // Insert mode moves the rest of the line right by one cell first.
            if (insert_ff && x0 < LASTX) begin
               d_shift = 1'b1;
               d_n     = 17'd1;
               d_stop  = x0 + 17'd1;
            end
         end
         ates_pkg::MODE_CSI: begin
            case (in_char)
               ates_pkg::CSI_ICH: begin
                  if (!wrap && p1e != 17'd0) begin
                     d_n    = (p1e > rem) ? rem : p1e;
                     d_fill = 1'b1;
                     d_lo   = here;
                     d_hi   = here + d_n - 17'd1;
                     d_stop = xe + d_n;
                     d_shift = (d_stop <= LASTX);
                  end
               end
               ates_pkg::CSI_CUU: begin
                  if (wrap) d_x = 17'd0;
                  d_y = sub_floor(ye, p1e);
               end
               ates_pkg::CSI_CUD: begin
                  if (wrap) d_x = 17'd0;
                  d_y = sat_r(ye + p1e);
               end
               ates_pkg::CSI_CUF, ates_pkg::CSI_HPR: d_x = sat_c(xe + p1e);
               ates_pkg::CSI_CUB: d_x = sat_c(sub_floor(xe, p1e));
               ates_pkg::CSI_CNL: begin
                  d_x = 17'd0;
                  d_y = sat_r(ye + p1e);
               end
               ates_pkg::CSI_CPL: begin
                  d_x = 17'd0;
                  d_y = sub_floor(ye, p1e);
               end
               ates_pkg::CSI_CHA, ates_pkg::CSI_HPA: d_x = sat_c(abs_pos(in_p1));
               ates_pkg::CSI_CUP, ates_pkg::CSI_HVP: begin
                  d_x = sat_c(abs_pos(in_p2));
                  d_y = sat_r(abs_pos(in_p1));
               end
               ates_pkg::CSI_VPA: d_y = sat_r(abs_pos(in_p1));
               ates_pkg::CSI_VPR: d_y = sat_r(ye + p1e);
               ates_pkg::CSI_ED, ates_pkg::CSI_EL: begin
                  case (p1e)
                     ates_pkg::ERASE_TO_END: begin
                        d_lo = here;
                        d_hi = hi_r;
                     end
                     ates_pkg::ERASE_TO_START: begin
                        d_lo = lo_r;
                        d_hi = incl;
                     end
                     ates_pkg::ERASE_ALL: begin
                        d_lo = lo_r;
                        d_hi = hi_r;
                     end
                     default: begin
                        d_lo = 17'd1;
                        d_hi = 17'd0;
                     end
                  endcase
                  d_fill = (d_lo <= d_hi);
               end
               ates_pkg::CSI_SGR: d_pen = ates_pkg::apply_sgr(in_p1, pen_ff);
               default: ;
            endcase
         end
         ates_pkg::MODE_SGR: d_pen = ates_pkg::apply_sgr(in_p1, pen_ff);
         ates_pkg::MODE_CR:  d_x = 17'd0;
         ates_pkg::MODE_LF:  d_y = sat_r(ye + 17'd1);
         ates_pkg::MODE_BS: begin
            if (xe == 17'd0) begin
               d_x = LASTX;
               d_y = sub_floor(ye, 17'd1);
            end else begin
               d_x = xe - 17'd1;
            end
         end
         ates_pkg::MODE_READ: begin
            if (17'(in_col) < COLS17 && 17'(in_row) < 17'(ROWS)) begin
               d_read = 1'b1;
            end else begin
               d_blank = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Next state.
   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         ates_pkg::ST_CLEAR: begin
            if (17'(fill_addr_ff) == LASTA) state_in = ates_pkg::ST_IDLE;
         end
         ates_pkg::ST_IDLE: begin
            if (accept) begin
               if (d_shift)      state_in = ates_pkg::ST_SHIFT_RD;
               else if (d_fill)  state_in = ates_pkg::ST_FILL;
               else if (d_wchar) state_in = ates_pkg::ST_WCHAR;
               else if (d_read)  state_in = ates_pkg::ST_READ;
               else              state_in = ates_pkg::ST_RESP;
            end
         end
         ates_pkg::ST_SHIFT_RD: state_in = ates_pkg::ST_SHIFT_WR;
         ates_pkg::ST_SHIFT_WR: begin
            if (XW'(sh_col_ff) == sh_stop_ff) begin
               if (pend_wchar_ff)     state_in = ates_pkg::ST_WCHAR;
               else if (pend_fill_ff) state_in = ates_pkg::ST_FILL;
               else                   state_in = ates_pkg::ST_RESP;
            end else begin
               state_in = ates_pkg::ST_SHIFT_RD;
            end
         end
         ates_pkg::ST_FILL: begin
            if (fill_addr_ff == fill_hi_ff) state_in = ates_pkg::ST_RESP;
         end
         ates_pkg::ST_WCHAR: state_in = ates_pkg::ST_RESP;
         // The read data is captured into the result register on the way to RESP.
         ates_pkg::ST_READ:  state_in = ates_pkg::ST_RESP;
         ates_pkg::ST_RESP: begin
            if (rsp_tready) state_in = ates_pkg::ST_IDLE;
         end
         default: state_in = ates_pkg::ST_CLEAR;
      endcase
   end

   // Outputs and RAM port control.
   always_comb begin : outputs
      req_tready = (state_ff == ates_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == ates_pkg::ST_RESP);
      ram_we     = 1'b0;
      ram_waddr  = fill_addr_ff;
      ram_wdata  = ates_pkg::BLANK_CELL;
      ram_raddr  = read_addr_ff;
      case (state_ff)
         ates_pkg::ST_CLEAR, ates_pkg::ST_FILL: ram_we = 1'b1;
         ates_pkg::ST_IDLE: ram_raddr = AW'(d_raddr);
         ates_pkg::ST_SHIFT_RD: begin
            ram_raddr = AW'(17'(base_ff) + 17'(sh_col_ff) - 17'(sh_n_ff));
         end
         ates_pkg::ST_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(17'(base_ff) + 17'(sh_col_ff));
            ram_wdata = ram_rdata;
         end
         ates_pkg::ST_WCHAR: begin
            ram_we    = 1'b1;
            ram_waddr = wchar_addr_ff;
            ram_wdata = wchar_data_ff;
         end
         default: ;
      endcase
   end

   // Datapath next values.
   always_comb begin : datapath
      x_in          = x_ff;
      y_in          = y_ff;
      pen_in        = pen_ff;
      insert_in     = insert_ff;
      cell_in       = cell_ff;
      fill_addr_in  = fill_addr_ff;
      fill_hi_in    = fill_hi_ff;
      pend_fill_in  = pend_fill_ff;
      pend_wchar_in = pend_wchar_ff;
      wchar_addr_in = wchar_addr_ff;
      wchar_data_in = wchar_data_ff;
      base_in       = base_ff;
      sh_col_in     = sh_col_ff;
      sh_stop_in    = sh_stop_ff;
      sh_n_in       = sh_n_ff;
      read_addr_in  = read_addr_ff;
      if (csr_write && csr_paddr[2] == ates_pkg::REG_INSERT_MODE) begin
         insert_in = csr_pwdata[0];
      end
      case (state_ff)
         ates_pkg::ST_CLEAR: fill_addr_in = AW'(17'(fill_addr_ff) + 17'd1);
         ates_pkg::ST_IDLE: begin
            if (accept) begin
               x_in          = XW'(d_x);
               y_in          = YW'(d_y);
               pen_in        = d_pen;
               cell_in       = d_blank ? ates_pkg::BLANK_CELL : '0;
               fill_addr_in  = AW'(d_lo);
               fill_hi_in    = AW'(d_hi);
               pend_fill_in  = d_fill;
               pend_wchar_in = d_wchar;
               wchar_addr_in = AW'(d_waddr);
               wchar_data_in = d_wdata;
               base_in       = AW'(d_base);
               sh_col_in     = CW'(LASTX);
               sh_stop_in    = XW'(d_stop);
               sh_n_in       = XW'(d_n);
               read_addr_in  = AW'(d_raddr);
            end
         end
         ates_pkg::ST_SHIFT_WR: sh_col_in = CW'(17'(sh_col_ff) - 17'd1);
         ates_pkg::ST_FILL: fill_addr_in = AW'(17'(fill_addr_ff) + 17'd1);
         ates_pkg::ST_READ: cell_in = ram_rdata;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ates_pkg::ST_CLEAR;
         x_ff         <= '0;
         y_ff         <= '0;
         pen_ff       <= ates_pkg::PEN_RESET;
         insert_ff    <= 1'b0;
         fill_addr_ff <= '0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         pen_ff       <= pen_in;
         insert_ff    <= insert_in;
         fill_addr_ff <= fill_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff       <= cell_in;
      fill_hi_ff    <= fill_hi_in;
      pend_fill_ff  <= pend_fill_in;
      pend_wchar_ff <= pend_wchar_in;
      wchar_addr_ff <= wchar_addr_in;
      wchar_data_ff <= wchar_data_in;
      base_ff       <= base_in;
      sh_col_ff     <= sh_col_in;
      sh_stop_ff    <= sh_stop_in;
      sh_n_ff       <= sh_n_in;
      read_addr_ff  <= read_addr_in;
   end

   // A cell read presents its address in the accepting cycle, so the RAM data
   // is ready in ST_READ and is captured there.
   ates_ram #(
      .WIDTH (CELLW),
      .DEPTH (TOTAL)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_tdata = {6'd0, cell_ff, 5'(y_ff), 7'(x_ff)};

endmodule
`default_nettype wire

FILE: src/ates_checker.sv
// ----------------------------------------------------------------------------
// ates_checker
// Port-level checks of the terminal screen engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ates_checker #(
   parameter int unsigned COLUMNS = ates_pkg::COLUMNS_DEF,
   parameter int unsigned ROWS    = ates_pkg::ROWS_DEF
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   `ATES_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")
   `ATES_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready, "second transfer accepted while busy")
   `ATES_NEVER(a_ready_with_result, clock, reset, req_tready && rsp_tvalid, "input ready while a result is pending")
   `ATES_NEVER(a_cursor_range, clock, reset, rsp_tvalid && (32'(rsp_tdata[6:0]) > COLUMNS || 32'(rsp_tdata[11:7]) >= ROWS), "cursor out of range")
endmodule

bind ansi_terminal_screen_engine_top ates_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_ates_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Screen engine testbench
// Drives parsed terminal items into the screen engine over the request stream
// and compares every response with a cell-level model of the screen, cursor
// and pen, under random idling on both sides and both insert settings.
// ----------------------------------------------------------------------------
module tb;

   localparam int NCOL = 80;
   localparam int NROW = 24;
   localparam int RANDOM_ITEMS = 1930;
   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ansi_terminal_screen_engine_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One screen item as it travels on the request stream.
   typedef struct {
      logic [2:0]  mode;
      logic [7:0]  ch;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [6:0]  rc;
      logic [4:0]  rr;
   } term_item_type;

   // One directed row: the item, and optionally the response it must give.
   typedef struct {
      term_item_type item;
      logic          fixed;
      logic [39:0]   resp;
   } directed_row_type;

   // Model of the screen: cells packed as char, style, fg, bg from bit 0.
   logic [21:0] cells [NCOL*NROW];
   int          cur_x, cur_y;
   logic [3:0]  pen_style;
   logic [4:0]  pen_fg, pen_bg;
   logic        ins_mode;

   logic [39:0] pending_resp [$];
   int          errors = 0;
   int          quiet_cycles = 0;
   bit          rx_hold = 1'b0;
   bit          no_idle = 1'b0;
   bit          stim_done = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int clamp_col(input int v);
      return v > NCOL - 1 ? NCOL - 1 : v;
   endfunction

   function automatic int clamp_row(input int v);
      return v > NROW - 1 ? NROW - 1 : v;
   endfunction

   function automatic int abs_position(input int p);
      return p == 0 ? 0 : p - 1;
   endfunction

   function automatic logic [21:0] blank_cell();
      return {ates_pkg::DEF_COLOR, ates_pkg::DEF_COLOR, 4'd0, 8'd0};
   endfunction

   function automatic void blank_range(input int lo, input int hi);
      if (hi > NCOL*NROW - 1) hi = NCOL*NROW - 1;
      for (int i = lo; i <= hi; i++) cells[i] = blank_cell();
   endfunction

   function automatic void shift_in_blanks(input int n);
      int base;
      if (cur_x >= NCOL || n == 0) return;
      if (n > NCOL - cur_x) n = NCOL - cur_x;
      base = cur_y * NCOL;
      for (int c = NCOL - 1; c >= cur_x + n; c--) cells[base+c] = cells[base+c-n];
      for (int c = cur_x; c < cur_x + n; c++) cells[base+c] = blank_cell();
   endfunction

   function automatic void update_pen(input int v);
      if (v == 0) begin
         pen_style = 0; pen_fg = ates_pkg::DEF_COLOR; pen_bg = ates_pkg::DEF_COLOR;
      end else if (v >= 1 && v <= 4) begin
         pen_style |= 4'(1 << (v - 1));
      end else if (v >= 30 && v <= 37) begin
         pen_fg = 5'(v - 30);
      end else if (v == 39) begin
         pen_fg = ates_pkg::DEF_COLOR;
      end else if (v >= 40 && v <= 47) begin
         pen_bg = 5'(v - 40);
      end else if (v == 49) begin
         pen_bg = ates_pkg::DEF_COLOR;
      end else if (v >= 90 && v <= 97) begin
         pen_fg = 5'(8 + v - 90);
      end else if (v >= 100 && v <= 107) begin
         pen_bg = 5'(8 + v - 100);
      end
   endfunction

   function automatic void erase_cells(input bit whole, input int sel);
      int rb, lo, hi;
      rb = cur_y * NCOL;
      lo = whole ? 0 : rb;
      hi = whole ? NCOL*NROW - 1 : rb + NCOL - 1;
      if (sel == 0) blank_range(rb + cur_x, hi);
      else if (sel == 1) blank_range(lo, rb + clamp_col(cur_x));
      else if (sel == 2) blank_range(lo, hi);
   endfunction

   function automatic void run_csi(input logic [7:0] fin, input int p1, input int p2);
      case (fin)
         ates_pkg::CSI_ICH: shift_in_blanks(p1);
         ates_pkg::CSI_CUU: begin
            if (cur_x >= NCOL) cur_x = 0;
            cur_y = p1 > cur_y ? 0 : cur_y - p1;
         end
         ates_pkg::CSI_CUD: begin
            if (cur_x >= NCOL) cur_x = 0;
            cur_y = clamp_row(cur_y + p1);
         end
         ates_pkg::CSI_CUF, ates_pkg::CSI_HPR: cur_x = clamp_col(cur_x + p1);
         ates_pkg::CSI_CUB: cur_x = clamp_col(p1 > cur_x ? 0 : cur_x - p1);
         ates_pkg::CSI_CNL: begin cur_x = 0; cur_y = clamp_row(cur_y + p1); end
         ates_pkg::CSI_CPL: begin cur_x = 0; cur_y = p1 > cur_y ? 0 : cur_y - p1; end
         ates_pkg::CSI_CHA, ates_pkg::CSI_HPA: cur_x = clamp_col(abs_position(p1));
         ates_pkg::CSI_CUP, ates_pkg::CSI_HVP: begin
            cur_x = clamp_col(abs_position(p2));
            cur_y = clamp_row(abs_position(p1));
         end
         ates_pkg::CSI_VPA: cur_y = clamp_row(abs_position(p1));
         ates_pkg::CSI_VPR: cur_y = clamp_row(cur_y + p1);
         ates_pkg::CSI_ED: erase_cells(1'b1, p1);
         ates_pkg::CSI_EL: erase_cells(1'b0, p1);
         ates_pkg::CSI_SGR: update_pen(p1);
         default: ;
      endcase
   endfunction

   // Advances the model by one item and returns the packed response.
   function automatic logic [39:0] predict_screen(input term_item_type it);
      logic [21:0] rd_cell;
      rd_cell = '0;
      case (ates_pkg::mode_type'(it.mode))
         ates_pkg::MODE_CHAR: begin
            if (cur_x >= NCOL) begin cur_x = 0; cur_y = clamp_row(cur_y + 1); end
            if (ins_mode) shift_in_blanks(1);
            cells[cur_y*NCOL + cur_x] = {pen_bg, pen_fg, pen_style, it.ch};
            cur_x++;
         end
         ates_pkg::MODE_CSI: run_csi(it.ch, it.p1, it.p2);
         ates_pkg::MODE_SGR: update_pen(it.p1);
         ates_pkg::MODE_CR: cur_x = 0;
         ates_pkg::MODE_LF: cur_y = clamp_row(cur_y + 1);
         ates_pkg::MODE_BS: begin
            if (cur_x == 0) begin
               if (cur_y > 0) cur_y--;
               cur_x = NCOL - 1;
            end else cur_x--;
         end
         ates_pkg::MODE_READ: begin
            if (it.rc < NCOL && it.rr < NROW) rd_cell = cells[it.rr*NCOL + it.rc];
            else rd_cell = blank_cell();
         end
         default: ;
      endcase
      return {6'd0, rd_cell, 5'(cur_y), 7'(cur_x)};
   endfunction

   function automatic logic [55:0] pack_item(input term_item_type it);
      return {1'b0, it.rr, it.rc, it.p2, it.p1, it.ch, it.mode};
   endfunction

   function automatic term_item_type make_item(input ates_pkg::mode_type m,
                                               input logic [7:0] ch,
                                               input logic [15:0] p1, input logic [15:0] p2,
                                               input logic [6:0] rc, input logic [4:0] rr);
      term_item_type it;
      it.mode = m; it.ch = ch; it.p1 = p1; it.p2 = p2; it.rc = rc; it.rr = rr;
      return it;
   endfunction

   // Random item, mostly well-formed commands with sensible counts.
   function automatic term_item_type random_item();
      term_item_type it;
      logic [7:0] finals [17];
      int pick;
      finals = '{ates_pkg::CSI_ICH, ates_pkg::CSI_CUU, ates_pkg::CSI_CUD, ates_pkg::CSI_CUF,
                 ates_pkg::CSI_CUB, ates_pkg::CSI_CNL, ates_pkg::CSI_CPL, ates_pkg::CSI_CHA,
                 ates_pkg::CSI_HPA, ates_pkg::CSI_CUP, ates_pkg::CSI_HVP, ates_pkg::CSI_VPA,
                 ates_pkg::CSI_VPR, ates_pkg::CSI_HPR, ates_pkg::CSI_ED, ates_pkg::CSI_EL,
                 ates_pkg::CSI_SGR};
      it.ch = 8'($urandom);
      it.p1 = 16'($urandom_range(0, 90));
      it.p2 = 16'($urandom_range(0, 90));
      it.rc = 7'($urandom_range(0, 85));
      it.rr = 5'($urandom_range(0, 26));
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) begin
         it.p1 = 16'($urandom);
         it.p2 = 16'($urandom);
         it.rc = 7'($urandom);
         it.rr = 5'($urandom);
      end
      if (pick < 40) it.mode = ates_pkg::MODE_CHAR;
      else if (pick < 62) begin
         it.mode = ates_pkg::MODE_CSI;
         if ($urandom_range(0, 9) != 0) it.ch = finals[$urandom_range(0, 16)];
         if (it.ch == ates_pkg::CSI_ED || it.ch == ates_pkg::CSI_EL)
            it.p1 = 16'($urandom_range(0, 3));
         if (it.ch == ates_pkg::CSI_ED && $urandom_range(0, 3) != 0) it.p1 = 16'd5;
         if (it.ch == ates_pkg::CSI_SGR) it.p1 = 16'($urandom_range(0, 110));
      end else if (pick < 70) begin
         it.mode = ates_pkg::MODE_SGR;
         it.p1 = 16'($urandom_range(0, 110));
      end else if (pick < 75) it.mode = ates_pkg::MODE_CR;
      else if (pick < 79) it.mode = ates_pkg::MODE_LF;
      else if (pick < 83) it.mode = ates_pkg::MODE_BS;
      else if (pick < 98) it.mode = ates_pkg::MODE_READ;
      else it.mode = ates_pkg::MODE_NOP;
      return it;
   endfunction

   // Offers one item, waits for its transfer and queues its expected response.
   // The valid stays high after the transfer until the next idle cycle or wait.
   task automatic send_item(input term_item_type it, input logic fixed,
                            input logic [39:0] resp);
      logic [39:0] want;
      while (!no_idle && $urandom_range(0, 99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_item(it);
      do @(posedge clock); while (!req_tready);
      want = predict_screen(it);
      if (fixed && want !== resp) begin
         report_mismatch("directed row vs model", want, resp);
      end
      pending_resp.push_back(fixed ? resp : want);
   endtask

   task automatic write_insert_mode(input logic v);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * ates_pkg::REG_INSERT_MODE); csr_pwdata <= {31'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      ins_mode = v;
   endtask

   // Drops the request, waits for every expected response, then idles before returning.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_resp.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // Response side: random stalls, one long hold-off, and field-by-field checks.
   always @(posedge clock) begin
      logic [39:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_resp.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[6:0], -1);
         end else begin
            want = pending_resp.pop_front();
            if (rsp_tdata[6:0] !== want[6:0])
               report_mismatch("cursor_column", rsp_tdata[6:0], want[6:0]);
            if (rsp_tdata[11:7] !== want[11:7])
               report_mismatch("cursor_row", rsp_tdata[11:7], want[11:7]);
            if (rsp_tdata[19:12] !== want[19:12])
               report_mismatch("cell_char", rsp_tdata[19:12], want[19:12]);
            if (rsp_tdata[23:20] !== want[23:20])
               report_mismatch("cell_style", rsp_tdata[23:20], want[23:20]);
            if (rsp_tdata[28:24] !== want[28:24])
               report_mismatch("cell_fg", rsp_tdata[28:24], want[28:24]);
            if (rsp_tdata[33:29] !== want[33:29])
               report_mismatch("cell_bg", rsp_tdata[33:29], want[33:29]);
         end
      end
      rsp_tready <= !rx_hold && (no_idle || $urandom_range(0, 99) >= 19);
   end

   // Watchdog: counts cycles without any transfer; the clearing pass fits well inside.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Long receiver hold-off, counted here, while the sender keeps offering.
   initial begin
      wait (stim_done == 1'b0 && !reset);
      repeat (6000) @(posedge clock);
      rx_hold = 1'b1;
      repeat (300) @(posedge clock);
      rx_hold = 1'b0;
   end

   initial begin
      directed_row_type rows [$];
      directed_row_type r;
      logic [39:0] blank_resp;
      for (int i = 0; i < NCOL*NROW; i++) cells[i] = blank_cell();
      cur_x = 0; cur_y = 0; pen_style = 0;
      pen_fg = ates_pkg::DEF_COLOR; pen_bg = ates_pkg::DEF_COLOR;
      ins_mode = 1'b0;
      blank_resp = {6'd0, ates_pkg::DEF_COLOR, ates_pkg::DEF_COLOR, 4'd0, 8'd0, 5'd0, 7'd0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_insert_mode(1'b0);

      // Reads after reset, including out of range, return blanks at home.
      r.fixed = 1'b1; r.resp = blank_resp;
      r.item = make_item(ates_pkg::MODE_READ, 8'h00, 16'h0000, 16'h0000, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 7'd79, 5'd23);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_READ, 8'h00, 16'h0, 16'h0, 7'd127, 5'd31);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_READ, 8'h00, 16'h0, 16'h0, 7'd80, 5'd0);
      rows.push_back(r);
      // Cursor to the bottom right with huge parameters: the positions clamp.
      r.resp = {6'd0, 22'd0, 5'd23, 7'd79};
      r.item = make_item(ates_pkg::MODE_CSI, ates_pkg::CSI_CUP, 16'hFFFF, 16'hFFFF, 7'd0, 5'd0);
      rows.push_back(r);
      // A write in the last column leaves the wrap pending.
      r.resp = {6'd0, 22'd0, 5'd23, 7'd80};
      r.item = make_item(ates_pkg::MODE_CHAR, 8'hFF, 16'h0, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.fixed = 1'b0;
      r.item = make_item(ates_pkg::MODE_CSI, ates_pkg::CSI_CUF, 16'd1, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_CHAR, 8'h41, 16'h0, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_CHAR, 8'h42, 16'h0, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_LF, 8'h0, 16'h0, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_CSI, ates_pkg::CSI_VPR, 16'd2, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_CSI, ates_pkg::CSI_VPA, 16'd0, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_SGR, 8'h0, 16'd1, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_SGR, 8'h0, 16'd97, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_CSI, ates_pkg::CSI_SGR, 16'd107, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_SGR, 8'h0, 16'd999, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_CHAR, 8'h5A, 16'h0, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_READ, 8'h0, 16'h0, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_CSI, ates_pkg::CSI_ICH, 16'd200, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_CSI, ates_pkg::CSI_EL, 16'd1, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_CSI, ates_pkg::CSI_ED, 16'd7, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_CR, 8'h0, 16'h0, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_BS, 8'h0, 16'h0, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_NOP, 8'h68, 16'h0, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);
      r.item = make_item(ates_pkg::MODE_CSI, ates_pkg::CSI_ED, 16'd2, 16'h0, 7'd0, 5'd0);
      rows.push_back(r);

      foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].resp);

      // Random phases under alternating insert settings; one phase runs without idling.
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         write_insert_mode(phase[0]);
         no_idle = (phase == 2);
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_item(random_item(), 1'b0, '0);
      end
      no_idle = 1'b0;
      stim_done = 1'b1;

      wait_idle();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+src
src/ates_pkg.sv
src/ates_ram.sv
src/ansi_terminal_screen_engine_top.sv
src/ates_checker.sv
tb/tb.sv
